// ----- rtl/core/sliding_window_max_unit_macros.svh -----
// ----------------------------------------------------------------------------
// sliding window max unit assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAX_UNIT_MACROS_SVH
`define SLIDING_WINDOW_MAX_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// checked from reset release onwards
`define SWMU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define SWMU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWMU_ASSERT(lbl, prop, msg)
`define SWMU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// sliding window max package
// shared constants and the deque memory command struct
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int POS_W           = 16;
    localparam int CFG_W           = 7;

    localparam logic [CFG_W-1:0] WINDOW_RST = 7'd3;

    typedef struct packed {
        logic rd_back;
        logic rd_front;
        logic wr;
    } swm_mem_ctl_t;

endpackage

// ----- rtl/core/swm_store.sv -----
// ----------------------------------------------------------------------------
// sliding window max deque store
// value and position memories of the ring deque, one write port, registered
// reads: back value, value after the head and position at the head
// ----------------------------------------------------------------------------
module swm_store #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
    parameter int PTR_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
    input  logic                       clk,
    input  swm_pkg::swm_mem_ctl_t      ctl,
    input  logic [PTR_W-1:0]           back_addr,
    input  logic [PTR_W-1:0]           head_addr,
    input  logic [PTR_W-1:0]           next_addr,
    input  logic [PTR_W-1:0]           wr_addr,
    input  logic [SAMPLE_BITS-1:0]     wr_val,
    input  logic [swm_pkg::POS_W-1:0]  wr_pos,
    output logic [SAMPLE_BITS-1:0]     back_val,
    output logic [SAMPLE_BITS-1:0]     next_val,
    output logic [swm_pkg::POS_W-1:0]  head_pos
);
    import swm_pkg::*;

    logic [SAMPLE_BITS-1:0] val_mem [WINDOW_MAX];
    logic [POS_W-1:0]       pos_mem [WINDOW_MAX];

    logic [SAMPLE_BITS-1:0] back_val_reg;
    logic [SAMPLE_BITS-1:0] next_val_reg;
    logic [POS_W-1:0]       head_pos_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            val_mem[wr_addr] <= wr_val;
            pos_mem[wr_addr] <= wr_pos;
        end
        if (ctl.rd_back)
        begin
            back_val_reg <= val_mem[back_addr];
        end
        if (ctl.rd_front)
        begin
            next_val_reg <= val_mem[next_addr];
            head_pos_reg <= pos_mem[head_addr];
        end
    end

    assign back_val = back_val_reg;
    assign next_val = next_val_reg;
    assign head_pos = head_pos_reg;

endmodule

// ----- rtl/core/swm_ctrl.sv -----
// ----------------------------------------------------------------------------
// sliding window max sequencer
// ring pointers, counts and the per-item scan over the deque store
// ----------------------------------------------------------------------------
`include "sliding_window_max_unit_macros.svh"

module swm_ctrl #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
    parameter int PTR_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
    parameter int KW          = ($clog2(WINDOW_MAX + 1) > swm_pkg::CFG_W) ?
                                $clog2(WINDOW_MAX + 1) : swm_pkg::CFG_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [KW-1:0]                 k_len,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          restart,
    input  logic                          out_free,
    output logic                          res_valid,
    output logic [SAMPLE_BITS-1:0]        res_value,
    output swm_pkg::swm_mem_ctl_t         mem_ctl,
    output logic [PTR_W-1:0]              back_addr,
    output logic [PTR_W-1:0]              head_addr,
    output logic [PTR_W-1:0]              next_addr,
    output logic [PTR_W-1:0]              wr_addr,
    output logic [SAMPLE_BITS-1:0]        wr_val,
    output logic [swm_pkg::POS_W-1:0]     wr_pos,
    input  logic [SAMPLE_BITS-1:0]        back_val,
    input  logic [SAMPLE_BITS-1:0]        next_val,
    input  logic [swm_pkg::POS_W-1:0]     head_pos
);
    import swm_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } swm_state_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(WINDOW_MAX - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(WINDOW_MAX - 1) : p - 1'b1;
    endfunction

    swm_state_t                    state_reg, state_next;
    logic [PTR_W-1:0]              head_reg, head_next;
    logic [PTR_W-1:0]              tail_reg, tail_next;
    logic [CNT_W-1:0]              occ_reg, occ_next;
    logic [CNT_W-1:0]              filled_reg, filled_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                          first_reg, first_next;
    logic                          moved_reg, moved_next;
    logic [SAMPLE_BITS-1:0]        front_reg, front_next;

    logic                          accept;
    logic [POS_W-1:0]              age;
    logic                          expired;
    logic [CNT_W-1:0]              occ_a;
    logic [PTR_W-1:0]              head_a;
    logic [PTR_W-1:0]              tail_prev;
    logic                          pop;
    logic                          finish;
    logic                          full;
    logic [CNT_W-1:0]              filled_inc;
    logic [SAMPLE_BITS-1:0]        front_new;

    assign sample_stall = (state_reg != ST_IDLE);
    assign accept       = sample_valid && !sample_stall;

    assign age       = pos_reg - head_pos;
    assign expired   = first_reg && (occ_reg != '0) && (age >= POS_W'(k_len));
    assign occ_a     = occ_reg - CNT_W'(expired);
    assign head_a    = expired ? ring_next(head_reg) : head_reg;
    assign tail_prev = ring_prev(tail_reg);
    assign pop       = (state_reg == ST_SCAN) && (occ_a != '0) &&
                       ($signed(back_val) <= sample_reg);
    assign finish    = (state_reg == ST_SCAN) && !pop && out_free;
    assign full      = (occ_a == CNT_W'(WINDOW_MAX));

    assign filled_inc = (KW'(filled_reg) < k_len) ? filled_reg + 1'b1 : filled_reg;
    assign front_new  = (occ_a == '0) ? sample_reg :
                        ((expired || moved_reg) ? next_val : front_reg);

    assign head_addr = head_reg;
    assign next_addr = ring_next(head_reg);
    assign wr_addr   = tail_reg;
    assign wr_val    = sample_reg;
    assign wr_pos    = pos_reg;
    assign res_value = front_new;
    assign res_valid = finish && (KW'(filled_inc) >= k_len);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        occ_next    = occ_reg;
        filled_next = filled_reg;
        pos_next    = pos_reg;
        sample_next = sample_reg;
        first_next  = first_reg;
        moved_next  = moved_reg;
        front_next  = front_reg;
        mem_ctl     = '0;
        back_addr   = tail_prev;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sample_next      = sample;
                    first_next       = 1'b1;
                    moved_next       = 1'b0;
                    mem_ctl.rd_back  = 1'b1;
                    mem_ctl.rd_front = 1'b1;
                    state_next       = ST_SCAN;
                    if (restart)
                    begin
                        head_next   = '0;
                        tail_next   = '0;
                        occ_next    = '0;
                        pos_next    = '0;
                        filled_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (pop)
                begin
                    // drop the back entry and fetch the one before it
                    tail_next       = tail_prev;
                    occ_next        = occ_a - 1'b1;
                    head_next       = head_a;
                    first_next      = 1'b0;
                    moved_next      = moved_reg || expired;
                    mem_ctl.rd_back = 1'b1;
                    back_addr       = ring_prev(tail_prev);
                end
                else if (finish)
                begin
                    mem_ctl.wr  = !full;
                    tail_next   = full ? tail_reg : ring_next(tail_reg);
                    occ_next    = full ? occ_a : occ_a + 1'b1;
                    head_next   = head_a;
                    front_next  = front_new;
                    pos_next    = pos_reg + 1'b1;
                    filled_next = filled_inc;
                    first_next  = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            head_next   = '0;
            tail_next   = '0;
            occ_next    = '0;
            pos_next    = '0;
            filled_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            occ_reg    <= '0;
            filled_reg <= '0;
            pos_reg    <= '0;
            first_reg  <= 1'b0;
            moved_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            occ_reg    <= occ_next;
            filled_reg <= filled_next;
            pos_reg    <= pos_next;
            first_reg  <= first_next;
            moved_reg  <= moved_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        front_reg  <= front_next;
    end

    `SWMU_ASSERT_ALWAYS(a_occ_bound, !rst_n || (occ_reg <= CNT_W'(WINDOW_MAX)), "occupancy overflow")
    `SWMU_ASSERT_ALWAYS(a_fill_bound, !rst_n || (filled_reg <= CNT_W'(WINDOW_MAX)), "fill overflow")
    `SWMU_ASSERT(a_accept_scan, accept |=> (state_reg == ST_SCAN), "accepted item not scanned")
    `SWMU_ASSERT(a_done_nonempty, (finish && !cfg_write) |=> (occ_reg != '0), "deque empty after append")
    `SWMU_ASSERT(a_result_in_scan, res_valid |-> (state_reg == ST_SCAN), "result outside scan")

endmodule

// ----- rtl/core/sliding_window_max_unit.sv -----
// ----------------------------------------------------------------------------
// sliding window max unit
// Gives the largest signed sample of the last window_length samples, kept in
// a monotonic deque held in two single-write memories (values and positions).
// An item is taken while idle and then scanned; the scan drops deque entries
// from the back, as the back of the deque is read one entry per cycle through
// one memory read port, and every sample is dropped at most once. The scan
// ends once no back entry is dropped and the output register is free. No result
// is given until window_length samples of the current sequence have arrived.
// restart, or a write of window_length, begins a new sequence. window_length
// 0 acts as 1 and values above WINDOW_MAX act as WINDOW_MAX. The result sits
// in an output register, so the next item is taken while it waits.
// ----------------------------------------------------------------------------
module sliding_window_max_unit #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [swm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          restart,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic signed [SAMPLE_BITS-1:0] window_max
);
    import swm_pkg::*;

    localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int KW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0]              window_length_reg;
    logic [KW-1:0]                 wl_ext;
    logic [KW-1:0]                 k_len;

    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] window_max_reg;
    logic                          out_free;
    logic                          res_valid;
    logic [SAMPLE_BITS-1:0]        res_value;

    swm_mem_ctl_t                  mem_ctl;
    logic [PTR_W-1:0]              back_addr;
    logic [PTR_W-1:0]              head_addr;
    logic [PTR_W-1:0]              next_addr;
    logic [PTR_W-1:0]              wr_addr;
    logic [SAMPLE_BITS-1:0]        wr_val;
    logic [POS_W-1:0]              wr_pos;
    logic [SAMPLE_BITS-1:0]        back_val;
    logic [SAMPLE_BITS-1:0]        next_val;
    logic [POS_W-1:0]              head_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_RST;
        end
        else if (cfg_write)
        begin
            window_length_reg <= cfg_data;
        end
    end

    // clamp to 1..WINDOW_MAX
    assign wl_ext = KW'(window_length_reg);
    assign k_len  = (wl_ext == '0) ? KW'(1) :
                    ((wl_ext > KW'(WINDOW_MAX)) ? KW'(WINDOW_MAX) : wl_ext);

    assign out_free       = !out_valid_reg || !result_stall;
    assign out_valid_next = res_valid || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            window_max_reg <= $signed(res_value);
        end
    end

    assign result_valid = out_valid_reg;
    assign window_max   = window_max_reg;

    swm_ctrl #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .PTR_W       (PTR_W),
        .KW          (KW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .k_len        (k_len),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .restart      (restart),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res_value    (res_value),
        .mem_ctl      (mem_ctl),
        .back_addr    (back_addr),
        .head_addr    (head_addr),
        .next_addr    (next_addr),
        .wr_addr      (wr_addr),
        .wr_val       (wr_val),
        .wr_pos       (wr_pos),
        .back_val     (back_val),
        .next_val     (next_val),
        .head_pos     (head_pos)
    );

    swm_store #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .PTR_W       (PTR_W)
    ) u_store (
        .clk       (clk),
        .ctl       (mem_ctl),
        .back_addr (back_addr),
        .head_addr (head_addr),
        .next_addr (next_addr),
        .wr_addr   (wr_addr),
        .wr_val    (wr_val),
        .wr_pos    (wr_pos),
        .back_val  (back_val),
        .next_val  (next_val),
        .head_pos  (head_pos)
    );

endmodule

// ----- tb/tb_sliding_window_max_unit.sv -----
// ----------------------------------------------------------------------------
// sliding window max unit testbench
// Sends signed samples, some of them marked as the start of a new sequence,
// through several window lengths. These include zero, one, the largest window
// and values above it. A local deque predictor works out the expected window
// maxima and every result item is checked against them in order. A short
// directed table comes first. Random runs follow under changing sender and
// receiver idling, with one long receiver hold and one sender pause.
// ----------------------------------------------------------------------------
module tb_sliding_window_max_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import swm_pkg::*;

    localparam int WIN_MAX       = WINDOW_MAX_DEF;
    localparam int SMP_W         = SAMPLE_BITS_DEF;
    localparam int DRAIN_CYCLES  = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int STUCK_LIMIT   = 5000;
    localparam int EXP_AW        = 6;
    localparam int EXP_DEPTH     = 1 << EXP_AW;

    localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
    localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

    typedef enum int {IDLE_SENDER_LIGHT, IDLE_SENDER_HEAVY, IDLE_NONE} idle_mode_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] smp;
        logic                    rst;
        logic                    fixed;
        logic signed [SMP_W-1:0] want;
    } dir_row_t;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    cfg_write    = 1'b0;
    logic [CFG_W-1:0]        cfg_data     = WINDOW_RST;
    logic                    sample_valid = 1'b0;
    logic                    sample_stall;
    logic signed [SMP_W-1:0] sample       = '0;
    logic                    restart      = 1'b0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    logic signed [SMP_W-1:0] window_max;

    // predictor state
    logic signed [SMP_W-1:0] dq_val [WIN_MAX];
    logic [POS_W-1:0]        dq_pos [WIN_MAX];
    int unsigned             dq_head;
    int unsigned             dq_tail;
    int unsigned             dq_count;
    logic [POS_W-1:0]        seq_pos;
    int unsigned             seq_filled;
    logic [CFG_W-1:0]        win_reg;

    // expected results, oldest first
    logic signed [SMP_W-1:0] exp_buf [EXP_DEPTH];
    logic [EXP_AW-1:0]       exp_wr_ptr  = '0;
    logic [EXP_AW-1:0]       exp_rd_ptr  = '0;
    int                      exp_pending = 0;
    logic signed [SMP_W-1:0] last_sample = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    bit hold_req      = 1'b0;
    int mismatches    = 0;
    int items_sent    = 0;
    int maxima_checked = 0;
    int stuck_cycles  = 0;
    int win_settings  = 0;

    dir_row_t dir_rows [0:23] = '{
        '{SMP_MAX,        1'b1, 1'b0, 16'sd0},
        '{SMP_MIN,        1'b0, 1'b0, 16'sd0},
        '{SMP_MIN,        1'b0, 1'b1, SMP_MAX},
        '{SMP_MIN,        1'b0, 1'b1, SMP_MIN},
        '{16'sd0,         1'b0, 1'b1, 16'sd0},
        '{16'sd0,         1'b0, 1'b1, 16'sd0},
        '{-16'sd1,        1'b0, 1'b1, 16'sd0},
        '{16'sd5,         1'b1, 1'b0, 16'sd0},
        '{16'sd5,         1'b0, 1'b0, 16'sd0},
        '{16'sd5,         1'b0, 1'b1, 16'sd5},
        '{16'sh5555,      1'b0, 1'b0, 16'sd0},
        '{16'shAAAA,      1'b0, 1'b0, 16'sd0},
        '{16'sd100,       1'b1, 1'b0, 16'sd0},
        '{16'sd200,       1'b0, 1'b0, 16'sd0},
        '{16'sd300,       1'b0, 1'b1, 16'sd300},
        '{16'sd200,       1'b0, 1'b1, 16'sd300},
        '{16'sd100,       1'b0, 1'b1, 16'sd300},
        '{16'sd50,        1'b0, 1'b1, 16'sd200},
        '{-16'sd1,        1'b0, 1'b0, 16'sd0},
        '{16'sd7,         1'b1, 1'b0, 16'sd0},
        '{16'sd8,         1'b1, 1'b0, 16'sd0},
        '{16'sd9,         1'b1, 1'b0, 16'sd0},
        '{SMP_MIN,        1'b0, 1'b0, 16'sd0},
        '{SMP_MAX,        1'b0, 1'b1, SMP_MAX}
    };

    sliding_window_max_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .restart      (restart),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .window_max   (window_max)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned win_eff();
        if (win_reg == 0)
            return 1;
        if (win_reg > WIN_MAX)
            return WIN_MAX;
        return int'(win_reg);
    endfunction

    function automatic void clear_deque();
        dq_head    = 0;
        dq_tail    = 0;
        dq_count   = 0;
        seq_pos    = '0;
        seq_filled = 0;
    endfunction

    function automatic void add_expected(input logic signed [SMP_W-1:0] v);
        exp_buf[exp_wr_ptr] = v;
        exp_wr_ptr          = exp_wr_ptr + 1'b1;
        exp_pending++;
    endfunction

    function automatic void predict_window_max(input logic signed [SMP_W-1:0] s,
                                               input logic r, output bit emit,
                                               output logic signed [SMP_W-1:0] m);
        int unsigned      k;
        int unsigned      b;
        logic [POS_W-1:0] age;
        k = win_eff();
        if (r)
            clear_deque();
        // newest of equal values wins
        while (dq_count > 0)
        begin
            b = (dq_tail == 0) ? WIN_MAX - 1 : dq_tail - 1;
            if (dq_val[b] > s)
                break;
            dq_tail = b;
            dq_count--;
        end
        // expire the front
        while (dq_count > 0)
        begin
            age = seq_pos - dq_pos[dq_head];
            if (age < k)
                break;
            dq_head = (dq_head + 1 >= WIN_MAX) ? 0 : dq_head + 1;
            dq_count--;
        end
        if (dq_count < WIN_MAX)
        begin
            dq_val[dq_tail] = s;
            dq_pos[dq_tail] = seq_pos;
            dq_tail = (dq_tail + 1 >= WIN_MAX) ? 0 : dq_tail + 1;
            dq_count++;
        end
        seq_pos = seq_pos + 1'b1;
        if (seq_filled < k)
            seq_filled++;
        emit = (seq_filled >= k) && (dq_count > 0);
        m    = dq_val[dq_head];
    endfunction

    function automatic logic signed [SMP_W-1:0] pick_sample();
        int                      kind;
        logic signed [SMP_W-1:0] v;
        kind = $urandom_range(0, 99);
        if (kind < 35)
            v = SMP_W'($urandom);
        else if (kind < 55)
            v = SMP_W'($urandom_range(0, 16)) - 16'sd8;
        else if (kind < 75)
            v = last_sample - SMP_W'($urandom_range(0, 300));
        else if (kind < 95)
            v = last_sample + SMP_W'($urandom_range(0, 300));
        else
            v = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
        last_sample = v;
        return v;
    endfunction

    function automatic void set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER_LIGHT:
            begin
                send_idle_pct = 25;
                recv_idle_pct = 73;
            end
            IDLE_SENDER_HEAVY:
            begin
                send_idle_pct = 73;
                recv_idle_pct = 25;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endfunction

    task automatic send_item(input logic signed [SMP_W-1:0] s, input logic r,
                             output bit emit, output logic signed [SMP_W-1:0] m);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        restart      <= r;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        items_sent++;
        predict_window_max(s, r, emit, m);
    endtask

    task automatic sender_quiet();
        @(negedge clk);
        sample_valid <= 1'b0;
    endtask

    task automatic write_window(input logic [CFG_W-1:0] w);
        sender_quiet();
        wait (exp_pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= w;
        @(negedge clk);
        cfg_write <= 1'b0;
        win_reg = w;
        clear_deque();
        win_settings++;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] w, input int n, input idle_mode_t mode,
                             input bit allow_restart, input int hold_at, input int pause_at);
        bit                      emit;
        logic signed [SMP_W-1:0] m;
        logic                    r;
        write_window(w);
        set_idling(mode);
        for (int i = 0; i < n; i++)
        begin
            if (i == hold_at)
                hold_req = 1'b1;
            if (i == pause_at)
            begin
                sender_quiet();
                wait (exp_pending == 0);
            end
            r = allow_restart && ($urandom_range(0, 10 * win_eff() + 20) == 0);
            send_item(pick_sample(), r, emit, m);
            if (emit)
                add_expected(m);
        end
    endtask

    // result side: stall pattern, long hold on request
    always @(negedge clk)
    begin
        if (hold_req && hold_left == 0)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (exp_pending == 0)
            begin
                mismatches++;
                $display("%0t: window_max expected none, got %0d", $time, window_max);
            end
            else
            begin
                if (window_max !== exp_buf[exp_rd_ptr])
                begin
                    mismatches++;
                    $display("%0t: window_max expected %0d, got %0d",
                             $time, exp_buf[exp_rd_ptr], window_max);
                end
                exp_rd_ptr = exp_rd_ptr + 1'b1;
                exp_pending--;
                maxima_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || cfg_write)
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        bit                      emit;
        logic signed [SMP_W-1:0] m;
        win_reg = WINDOW_RST;
        clear_deque();
        set_idling(IDLE_SENDER_LIGHT);
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].smp, dir_rows[i].rst, emit, m);
            if (emit)
                add_expected(dir_rows[i].fixed ? dir_rows[i].want : m);
        end

        run_phase(7'd1,   150, IDLE_SENDER_LIGHT, 1'b1, -1, -1);
        run_phase(7'd0,   100, IDLE_SENDER_LIGHT, 1'b1, -1, -1);
        run_phase(7'd64,  250, IDLE_SENDER_LIGHT, 1'b1, -1, -1);
        run_phase(7'd127, 200, IDLE_SENDER_HEAVY, 1'b1, -1, -1);
        run_phase(7'd2,   150, IDLE_SENDER_HEAVY, 1'b1, -1, -1);
        run_phase(CFG_W'($urandom_range(3, 20)), 150, IDLE_SENDER_HEAVY, 1'b1, -1, -1);
        run_phase(7'd65,  200, IDLE_NONE, 1'b1, -1, -1);
        run_phase(7'd7,   200, IDLE_NONE, 1'b1, 50, 120);

        sender_quiet();
        wait (exp_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d samples sent over %0d window settings plus reset length,",
                 items_sent, win_settings);
        $display("%0d window maxima checked in order under stalls and restarts",
                 maxima_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/swm_pkg.sv
rtl/core/swm_store.sv
rtl/core/swm_ctrl.sv
rtl/core/sliding_window_max_unit.sv
tb/tb_sliding_window_max_unit.sv
